// ----- src/mfd_pkg.sv -----
package mfd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_V1_START  = 3'd0;
    localparam logic [2:0] REG_V2_START  = 3'd1;
    localparam logic [2:0] REG_V1_HEADER = 3'd2;
    localparam logic [2:0] REG_V2_HEADER = 3'd3;
    localparam logic [2:0] REG_CRC       = 3'd4;
    localparam logic [2:0] REG_SIG       = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Values after reset, as in the published frame layout.
    localparam logic [7:0] V1_START_RST  = 8'd254;
    localparam logic [7:0] V2_START_RST  = 8'd253;
    localparam logic [4:0] V1_HEADER_RST = 5'd6;
    localparam logic [4:0] V2_HEADER_RST = 5'd10;
    localparam logic [2:0] CRC_RST       = 3'd2;
    localparam logic [4:0] SIG_RST       = 5'd13;

    // Parser phases.
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    typedef logic [8:0] count_t;

endpackage

// ----- src/mavlink_frame_delimiter_core.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte
// m_        out        m_valid/m_ready    m_frame_byte, m_frame_version, m_byte_position,
//                                         m_first_mark, m_last_mark
// cfg_      in         cfg_we             cfg_addr, cfg_data
//
// One byte is accepted per cycle; a frame byte reaches the output register in the next
// cycle. The parser state and the output register update at the same edge.
// Reset is synchronous and active low; it restores the default start values and sizes.
// The input stalls only when the output register is full and m_ready is low.
module mavlink_frame_delimiter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_frame_byte,
    output logic                             m_frame_version,
    output logic [8:0]                       m_byte_position,
    output logic                             m_first_mark,
    output logic                             m_last_mark,
    input  logic                             cfg_we,
    input  logic [mfd_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mfd_pkg::*;

    logic [7:0] v1_start_reg;
    logic [7:0] v2_start_reg;
    logic [4:0] v1_header_reg;
    logic [4:0] v2_header_reg;
    logic [2:0] crc_reg;
    logic [4:0] sig_reg;

    logic [1:0] phase_reg, phase_next;
    logic       is_v2_reg, is_v2_next;
    count_t     pos_reg, pos_next;
    count_t     rem_reg, rem_next;
    logic [7:0] plen_reg, plen_next;
    logic       sflag_reg, sflag_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       ver_reg, ver_next;
    count_t     opos_reg, opos_next;
    logic       first_reg, first_next;
    logic       last_reg, last_next;
    logic       emit;

    logic       s_fire;
    logic [4:0] hdr_size;
    logic [4:0] hdr_end;
    count_t     pos_inc;
    logic [7:0] plen_eff;
    logic       sflag_eff;
    count_t     rem_sum;
    count_t     rem_dec;
    logic       header_done;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_start_reg  <= V1_START_RST;
            v2_start_reg  <= V2_START_RST;
            v1_header_reg <= V1_HEADER_RST;
            v2_header_reg <= V2_HEADER_RST;
            crc_reg       <= CRC_RST;
            sig_reg       <= SIG_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_V1_START:  v1_start_reg  <= cfg_data[7:0];
                REG_V2_START:  v2_start_reg  <= cfg_data[7:0];
                REG_V1_HEADER: v1_header_reg <= cfg_data[4:0];
                REG_V2_HEADER: v2_header_reg <= cfg_data[4:0];
                REG_CRC:       crc_reg       <= cfg_data[2:0];
                REG_SIG:       sig_reg       <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // The length byte and the signed flag may arrive in the very cycle that ends
    // the header, so the body count is built from the incoming byte when needed.
    assign hdr_size    = is_v2_reg ? v2_header_reg : v1_header_reg;
    assign hdr_end     = (hdr_size < 5'd2) ? 5'd1 : hdr_size - 5'd1;
    assign pos_inc     = pos_reg + 9'd1;
    assign plen_eff    = (pos_inc == 9'd1) ? s_rx_byte : plen_reg;
    assign sflag_eff   = (pos_inc == 9'd2 && is_v2_reg) ? s_rx_byte[0] : sflag_reg;
    assign rem_sum     = {1'b0, plen_eff} + {6'd0, crc_reg}
                       + ((is_v2_reg && sflag_eff) ? {4'd0, sig_reg} : 9'd0);
    assign rem_dec     = rem_reg - 9'd1;
    assign header_done = pos_inc >= {4'd0, hdr_end};

    always_comb begin
        phase_next = phase_reg;
        is_v2_next = is_v2_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        plen_next  = plen_reg;
        sflag_next = sflag_reg;
        emit       = 1'b0;
        ver_next   = is_v2_reg;
        opos_next  = pos_inc;
        first_next = 1'b0;
        last_next  = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                emit       = 1'b1;
                pos_next   = pos_inc;
                plen_next  = plen_eff;
                sflag_next = sflag_eff;
                if (header_done) begin
                    rem_next = rem_sum;
                    if (rem_sum == 9'd0) begin
                        last_next  = 1'b1;
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                emit     = 1'b1;
                pos_next = pos_inc;
                rem_next = rem_dec;
                if (rem_dec == 9'd0) begin
                    last_next  = 1'b1;
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                opos_next  = 9'd0;
                first_next = 1'b1;
                if (s_rx_byte == v1_start_reg) begin
                    emit       = 1'b1;
                    is_v2_next = 1'b0;
                    ver_next   = 1'b0;
                end else if (s_rx_byte == v2_start_reg) begin
                    emit       = 1'b1;
                    is_v2_next = 1'b1;
                    ver_next   = 1'b1;
                end
                if (emit) begin
                    phase_next = PH_HEADER;
                    pos_next   = 9'd0;
                    rem_next   = 9'd0;
                    plen_next  = 8'd0;
                    sflag_next = 1'b0;
                end
            end
        endcase

        // Leaving a frame restores the idle defaults.
        if (last_next) begin
            is_v2_next = 1'b1;
            pos_next   = 9'd0;
            rem_next   = 9'd0;
            plen_next  = 8'd0;
            sflag_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            is_v2_reg   <= 1'b1;
            pos_reg     <= 9'd0;
            rem_reg     <= 9'd0;
            plen_reg    <= 8'd0;
            sflag_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg <= phase_next;
                is_v2_reg <= is_v2_next;
                pos_reg   <= pos_next;
                rem_reg   <= rem_next;
                plen_reg  <= plen_next;
                sflag_reg <= sflag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            byte_reg  <= s_rx_byte;
            ver_reg   <= ver_next;
            opos_reg  <= opos_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = byte_reg;
    assign m_frame_version = ver_reg;
    assign m_byte_position = opos_reg;
    assign m_first_mark    = first_reg;
    assign m_last_mark     = last_reg;

    a_first_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && first_reg |-> opos_reg == 9'd0)
        else $error("start byte reported at a nonzero position");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(first_reg && last_reg))
        else $error("start byte marked as closing the frame");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> rem_reg != 9'd0)
        else $error("body phase with nothing left to count");

    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT |-> pos_reg == 9'd0 && rem_reg == 9'd0 && is_v2_reg)
        else $error("hunting with stale frame state");

    a_last_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && emit && last_next |=> phase_reg == PH_HUNT)
        else $error("frame closed but parser did not return to hunting");

endmodule
